@@ rtl/ordered_list_engine_macros.svh @@
// Assertion macros used by the ordered list engine checker.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ole_pkg.sv @@
// Types and constants of the ordered list engine.
`default_nettype none

package ole_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_GET  = 3'd0,
        CMD_SET  = 3'd1,
        CMD_DEL  = 3'd2,
        CMD_INS  = 3'd3,
        CMD_CNT  = 3'd4,
        CMD_FIND = 3'd5
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int DATA_W   = 32;
    localparam int AT_W     = 6;
    localparam int MCNT_W   = 7;
    localparam int OCC_W    = 7;
    localparam int STAT_W   = 2;

    // input beat layout
    localparam int S_CMD_LSB  = 0;
    localparam int S_POS_LSB  = S_CMD_LSB + CMD_W;
    localparam int S_WORD_LSB = S_POS_LSB + POS_W;
    localparam int S_BITS     = S_WORD_LSB + WORD_W;
    localparam int S_TDATA_W  = ((S_BITS + 7) / 8) * 8;

    // output beat layout
    localparam int M_DATA_LSB = 0;
    localparam int M_HIT_LSB  = M_DATA_LSB + DATA_W;
    localparam int M_AT_LSB   = M_HIT_LSB + 1;
    localparam int M_MCNT_LSB = M_AT_LSB + AT_W;
    localparam int M_OCC_LSB  = M_MCNT_LSB + MCNT_W;
    localparam int M_STAT_LSB = M_OCC_LSB + OCC_W;
    localparam int M_BITS     = M_STAT_LSB + STAT_W;
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8;

    // update strobes broadcast to every cell
    typedef struct packed {
        logic             set_en;
        logic             ins_en;
        logic             del_en;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/ole_cell.sv @@
// One list cell: an entry with its valid bit, plus one stage of the search pass.
`default_nettype none

module ole_cell
    import ole_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 32,
    parameter int CW        = 7,
    parameter int IW        = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic [WORD_BITS-1:0] word_i,
    input  wire logic [WORD_BITS-1:0] left_entry,
    input  wire logic                 left_valid,
    input  wire logic [WORD_BITS-1:0] right_entry,
    input  wire logic                 right_valid,
    output logic      [WORD_BITS-1:0] entry_o,
    output logic                      valid_o,
    input  wire logic [CW-1:0]        acc_cnt_i,
    input  wire logic                 acc_hit_i,
    input  wire logic [IW-1:0]        acc_at_i,
    input  wire logic [WORD_BITS-1:0] acc_data_i,
    output logic      [CW-1:0]        acc_cnt_o,
    output logic                      acc_hit_o,
    output logic      [IW-1:0]        acc_at_o,
    output logic      [WORD_BITS-1:0] acc_data_o
);

    logic [WORD_BITS-1:0] entry_reg, entry_next;
    logic                 valid_reg, valid_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 hit_reg, hit_next;
    logic [IW-1:0]        at_reg, at_next;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic                 is_pos, above_pos, match;

    assign is_pos    = (32'(ctrl.pos) == 32'(INDEX));
    assign above_pos = (32'(INDEX) > 32'(ctrl.pos));
    assign match     = valid_reg && (entry_reg == word_i);

    // entry update: write in place, shift up from the left, shift down from the right
    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.set_en && is_pos) begin
            entry_next = word_i;
        end else if (ctrl.ins_en && is_pos) begin
            entry_next = word_i;
            valid_next = 1'b1;
        end else if (ctrl.ins_en && above_pos) begin
            entry_next = left_entry;
            valid_next = left_valid;
        end else if (ctrl.del_en && (is_pos || above_pos)) begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    // search stage: running match count, first hit, word at the addressed cell
    always_comb begin
        cnt_next  = acc_cnt_i + CW'(match);
        hit_next  = acc_hit_i | match;
        at_next   = (match && !acc_hit_i) ? IW'(INDEX) : acc_at_i;
        data_next = is_pos ? entry_reg : acc_data_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        cnt_reg   <= cnt_next;
        hit_reg   <= hit_next;
        at_reg    <= at_next;
        data_reg  <= data_next;
    end

    assign entry_o    = entry_reg;
    assign valid_o    = valid_reg;
    assign acc_cnt_o  = cnt_reg;
    assign acc_hit_o  = hit_reg;
    assign acc_at_o   = at_reg;
    assign acc_data_o = data_reg;

endmodule

`default_nettype wire

@@ rtl/ordered_list_engine.sv @@
// Ordered list engine: a chain of cells holding an ordered list of data words.
//
// Input channel (s_*): one beat carries one command: get, set, delete,
// insert, count matches or find first. Result channel (m_*): exactly one
// beat per command, with the word read, replaced or removed, the find and
// count results, the occupancy after the command and a status code.
// After the input beat is taken, a command passes the scan state, then the
// finish state, which loads the result register and raises m_tvalid. The
// search pass ripples through the chain one cell per cycle: the accumulated
// match count, first hit and addressed word move from cell to cell. A new
// command is taken only in the idle state, after the last one has finished.
// Updates land in the finish cycle in every cell at once: insert and
// delete hand each word to the neighbor cell, so no shift sweep is needed.
// Reset (aresetn low, synchronous) empties the list: all valid bits and the
// count clear, and the result register drops m_tvalid.
// Stall: a finished result sits in the output register until m_tready; the
// next input beat is still taken meanwhile and its finish cycle waits for
// the output register to free up. Commands change nothing while waiting.
`default_nettype none

module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [2:0] cmd, [9:3] position, [41:10] word, upper bits unused
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] data_out, [32] hit, [38:33] found_at, [45:39] match_count,
    // [52:46] occupancy, [54:53] status, [55] zero
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);  // holds 0..CAPACITY
    localparam int IW = $clog2(CAPACITY);      // cell index

    // control
    state_t               state_reg, state_next;
    logic [IW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // command held for the whole scan
    logic [CMD_W-1:0]     cmd_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 take_in;
    logic                 out_free;
    logic                 finish;
    logic                 below_count;   // pos < count
    logic                 upto_count;    // pos <= count
    logic                 full;
    cell_ctrl_t           ctrl;

    // chain wiring; search stage k feeds cell k, cell k drives stage k+1
    logic [WORD_BITS-1:0] entry   [CAPACITY];
    logic                 valid   [CAPACITY];
    logic [CW-1:0]        acc_cnt [CAPACITY+1];
    logic                 acc_hit [CAPACITY+1];
    logic [IW-1:0]        acc_at  [CAPACITY+1];
    logic [WORD_BITS-1:0] acc_data[CAPACITY+1];

    // result fields
    logic [DATA_W-1:0]    res_data;
    logic                 res_hit;
    logic [AT_W-1:0]      res_at;
    logic [MCNT_W-1:0]    res_mcnt;
    status_t              res_status;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign below_count = (32'(pos_reg) < 32'(count_reg));
    assign upto_count  = (32'(pos_reg) <= 32'(count_reg));
    assign full        = (count_reg == CW'(CAPACITY));

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_cnt_reg == IW'(CAPACITY - 1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        finish   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_SCAN: begin
            end
            S_FINISH: begin
                finish = out_free;
            end
            default: begin
            end
        endcase
    end

    assign take_in       = s_tvalid && s_tready;
    assign scan_cnt_next = (state_reg == S_SCAN) ? scan_cnt_reg + IW'(1) : '0;

    // ---------------- update strobes and new count ----------------
    always_comb begin
        ctrl.set_en = 1'b0;
        ctrl.ins_en = 1'b0;
        ctrl.del_en = 1'b0;
        ctrl.pos    = pos_reg;
        count_next  = count_reg;
        if (finish) begin
            case (cmd_t'(cmd_reg))
                CMD_SET: begin
                    ctrl.set_en = below_count;
                end
                CMD_DEL: begin
                    ctrl.del_en = below_count;
                    if (below_count) begin
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_INS: begin
                    ctrl.ins_en = upto_count && !full;
                    if (upto_count && !full) begin
                        count_next = count_reg + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- result fields from the end of the chain ----------------
    always_comb begin
        res_data   = '0;
        res_hit    = 1'b0;
        res_at     = '0;
        res_mcnt   = '0;
        res_status = ST_OK;
        case (cmd_t'(cmd_reg))
            CMD_GET, CMD_SET, CMD_DEL: begin
                if (below_count) begin
                    res_data = DATA_W'(acc_data[CAPACITY]);
                end else begin
                    res_status = ST_RANGE;
                end
            end
            CMD_INS: begin
                if (!upto_count) begin
                    res_status = ST_RANGE;
                end else if (full) begin
                    res_status = ST_FULL;
                end
            end
            CMD_CNT: begin
                res_mcnt = MCNT_W'(acc_cnt[CAPACITY]);
            end
            CMD_FIND: begin
                res_hit = acc_hit[CAPACITY];
                if (acc_hit[CAPACITY]) begin
                    res_at = AT_W'(acc_at[CAPACITY]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[M_DATA_LSB +: DATA_W] = res_data;
        m_tdata_next[M_HIT_LSB]            = res_hit;
        m_tdata_next[M_AT_LSB   +: AT_W]   = res_at;
        m_tdata_next[M_MCNT_LSB +: MCNT_W] = res_mcnt;
        m_tdata_next[M_OCC_LSB  +: OCC_W]  = OCC_W'(count_next);
        m_tdata_next[M_STAT_LSB +: STAT_W] = res_status;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            cmd_reg  <= s_tdata[S_CMD_LSB +: CMD_W];
            pos_reg  <= s_tdata[S_POS_LSB +: POS_W];
            word_reg <= WORD_BITS'(s_tdata[S_WORD_LSB +: WORD_W]);
        end
        if (finish) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- cell chain ----------------
    assign acc_cnt[0]  = '0;
    assign acc_hit[0]  = 1'b0;
    assign acc_at[0]   = '0;
    assign acc_data[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] l_entry, r_entry;
        logic                 l_valid, r_valid;

        if (i == 0) begin : g_first
            assign l_entry = '0;
            assign l_valid = 1'b0;
        end else begin : g_mid_l
            assign l_entry = entry[i-1];
            assign l_valid = valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign r_entry = '0;
            assign r_valid = 1'b0;
        end else begin : g_mid_r
            assign r_entry = entry[i+1];
            assign r_valid = valid[i+1];
        end

        ole_cell #(
            .INDEX     (i),
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .IW        (IW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .word_i      (word_reg),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry_o     (entry[i]),
            .valid_o     (valid[i]),
            .acc_cnt_i   (acc_cnt[i]),
            .acc_hit_i   (acc_hit[i]),
            .acc_at_i    (acc_at[i]),
            .acc_data_i  (acc_data[i]),
            .acc_cnt_o   (acc_cnt[i+1]),
            .acc_hit_o   (acc_hit[i+1]),
            .acc_at_o    (acc_at[i+1]),
            .acc_data_o  (acc_data[i+1])
        );
    end

endmodule

`default_nettype wire

@@ rtl/ole_checker.sv @@
// Port-level checks for the ordered list engine, bound to the top level.
`default_nettype none

`include "ordered_list_engine_macros.svh"

module ole_checker
    import ole_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic s_beat;
    logic m_hit;
    logic [STAT_W-1:0] m_status;

    assign s_beat   = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]);
    assign m_hit    = m_tdata[M_HIT_LSB];
    assign m_status = m_tdata[M_STAT_LSB +: STAT_W];

    // a stalled result holds
    `OLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one command in flight: no beat taken right after another
    `OLE_ASSERT_NEXT(a_busy_after_take, s_beat, !s_tready, "input taken while a command runs")

    // status is never the unused code
    `OLE_ASSERT_NOW(a_status_code, m_tvalid, m_status != 2'd3, "undefined status code")

    // a find hit is a clean result: ok status, no data word
    `OLE_ASSERT_NOW(a_hit_clean, m_tvalid && m_hit, (m_status == ST_OK) && (m_tdata[M_DATA_LSB +: DATA_W] == '0), "hit with status or data set")

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);

`default_nettype wire
